// File: rtl/pip_pkg.sv
// Package for the point-in-polygon tester: sizes, vertex type, control types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package pip_pkg;

  // Polygon storage and coordinate sizes
  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = ADDR_W + 1;

  // Fixed field widths of the request and result channels
  localparam int IDX_W     = 6;
  localparam int FIELD_W   = 16;
  localparam int COUNT_W   = 16;
  localparam int CFG_W     = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CFG_W-1:0]   VCOUNT_RESET = CFG_W'(4);

  // Edge arithmetic widths: differences, products, product difference
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  // Request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
  } vertex_t;

  // Tag that travels with each vertex read
  typedef struct packed {
    logic vld;
    logic first;
  } rd_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/pip_intf.sv
// Request and result channel interfaces of the point-in-polygon tester.
// Depends on pip_pkg for field widths.
`default_nettype none

interface pip_req_if import pip_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [IDX_W-1:0]          vertex_index;
  logic signed [FIELD_W-1:0] coord_x;
  logic signed [FIELD_W-1:0] coord_y;
  logic                      last_point;

  modport source (output valid, opcode, vertex_index, coord_x, coord_y, last_point,
                  input ready);
  modport sink (input valid, opcode, vertex_index, coord_x, coord_y, last_point,
                output ready);
endinterface

interface pip_res_if import pip_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               inside_res;
  logic [COUNT_W-1:0] point_number;
  logic [COUNT_W-1:0] inside_count;
  logic               any_inside;
  logic [COUNT_W-1:0] first_inside_index;
  logic               group_end;

  modport source (output valid, inside_res, point_number, inside_count, any_inside,
                  first_inside_index, group_end, input ready);
  modport sink (input valid, inside_res, point_number, inside_count, any_inside,
                first_inside_index, group_end, output ready);
endinterface

`default_nettype wire

// File: rtl/pip_vertex_mem.sv
// Vertex store: one write port, one read port with registered read data.
// Depends on pip_pkg for depth and the vertex type.
`default_nettype none

module pip_vertex_mem import pip_pkg::*; (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire vertex_t           wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output vertex_t                rd_data
);

  vertex_t mem [MAX_VERTICES];

  // Write a loaded vertex
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one vertex per cycle while rd_en is high
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/pip_edge_unit.sv
// Edge crossing unit: forms each edge from consecutive vertex reads, tests it
// by cross-multiplication over two stages and keeps the crossing parity.
// Depends on pip_pkg.
`default_nettype none

module pip_edge_unit import pip_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire rd_tag_t                       tag,
  input  wire vertex_t                       vtx,
  input  wire logic signed [COORD_WIDTH-1:0] px,
  input  wire logic signed [COORD_WIDTH-1:0] py,
  output logic                               parity,
  output logic                               busy
);

  vertex_t prev;

  logic signed [DW-1:0] xi, yi, xj, yj, pxe, pye;
  logic signed [DW-1:0] dx, dy, ex, ey;
  logic signed [PW-1:0] p1_c, p2_c;
  logic                 straddle_c, dyneg_c;

  logic                 e_vld;
  logic                 e_straddle;
  logic                 e_dyneg;
  logic signed [PW-1:0] e_p1, e_p2;

  logic signed [SW-1:0] s;
  logic                 crosses;

  // Hold the previous vertex of the walk
  always_ff @(posedge clk) begin
    if (tag.vld) begin
      prev <= vtx;
    end
  end

  // Stage one: differences and the two products
  always_comb begin
    xi  = DW'($signed(prev.x));
    yi  = DW'($signed(prev.y));
    xj  = DW'($signed(vtx.x));
    yj  = DW'($signed(vtx.y));
    pxe = DW'(px);
    pye = DW'(py);
    dx  = xj - xi;
    dy  = yj - yi;
    ex  = xi - pxe;
    ey  = yi - pye;
    p1_c = ex * dy;
    p2_c = ey * dx;
    straddle_c = (yi < pye) != (yj < pye);
    dyneg_c    = yj < yi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= tag.vld && !tag.first;
    end
  end

  always_ff @(posedge clk) begin
    e_p1       <= p1_c;
    e_p2       <= p2_c;
    e_straddle <= straddle_c;
    e_dyneg    <= dyneg_c;
  end

  // Stage two: the sign of the product difference must match the sign of dy
  always_comb begin
    s       = SW'(e_p1) - SW'(e_p2);
    crosses = e_straddle && (s != '0) && (s[SW-1] == e_dyneg);
  end

  // Toggle parity on each counted edge, clear at query start
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      parity <= 1'b0;
    end else if (e_vld && crosses) begin
      parity <= !parity;
    end
  end

  assign busy = e_vld;

endmodule

`default_nettype wire

// File: rtl/point_in_polygon_test.sv
// Point-in-polygon tester, top level: request control, vertex walk, group
// statistics and the result register. Depends on pip_pkg, pip_intf,
// pip_vertex_mem and pip_edge_unit.
`default_nettype none

// Holds a closed polygon of up to 64 vertices and tests query points by the
// even-odd crossing rule, counting an edge when exactly one endpoint lies
// below the point and its crossing lies strictly right of it; the crossing is
// decided exactly by cross-multiplication. A load request writes one vertex
// and leaves the block ready for the next request. In a query, n being
// vertex_count capped at 64, the vertex memory is read once per cycle,
// vertex 0 through n-1 and vertex 0 again for the closing edge, followed by
// the drain of the edge pipeline and the hand-off. With a vertex count of
// zero the walk is skipped. A stalled result output holds the query in
// hand-off until the result register frees up. A finished result waits in an
// output register while the next request is accepted. Per group of queries
// ended by last_point the block reports the point position, the number of
// inside points and the position of the first inside point, all saturating
// at 65535. vertex_count may only be written while no request is in flight;
// reading a vertex slot never loaded gives an undefined answer.

module point_in_polygon_test import pip_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  pip_req_if.sink               req,
  pip_res_if.source             res
);

  state_t state, state_next;

  logic [CFG_W-1:0]  vertex_count;
  logic [VCNT_W-1:0] n_eff;
  logic [VCNT_W-1:0] rd_cnt;
  logic [ADDR_W-1:0] rd_addr;
  rd_tag_t           rd_tag;

  logic signed [COORD_WIDTH-1:0] px, py;
  logic                          last;

  logic    in_ready, rd_issue, finish_ok, finish;
  logic    acc, acc_load, acc_query, load_we;
  vertex_t rd_data;
  vertex_t wr_vtx;
  logic    parity, edge_busy;

  logic [COUNT_W-1:0] pos, total, first_pos;
  logic               seen;
  logic [COUNT_W-1:0] total_upd, first_upd;
  logic               seen_upd;

  logic               out_vld;
  logic               o_inside, o_any, o_end;
  logic [COUNT_W-1:0] o_num, o_count, o_first;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // Cap the vertex count at the store depth
  always_comb begin
    if (int'(vertex_count) > MAX_VERTICES) begin
      n_eff = VCNT_W'(MAX_VERTICES);
    end else begin
      n_eff = VCNT_W'(vertex_count);
    end
  end

  assign acc       = req.valid && in_ready;
  assign acc_load  = acc && (req.opcode == OP_LOAD);
  assign acc_query = acc && (req.opcode == OP_QUERY);
  assign load_we   = acc_load && (int'(req.vertex_index) < MAX_VERTICES);
  assign wr_vtx.x  = COORD_WIDTH'($unsigned(req.coord_x));
  assign wr_vtx.y  = COORD_WIDTH'($unsigned(req.coord_y));
  assign req.ready = in_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc_query) begin
          state_next = (n_eff != '0) ? ST_WALK : ST_DRAIN;
        end
      end
      ST_WALK: begin
        if (rd_cnt == n_eff) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_tag.vld && !edge_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    rd_issue = 1'b0;
    finish   = 1'b0;
    case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_WALK:  rd_issue = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  finish = finish_ok;
      default:  ;
    endcase
  end

  assign finish_ok = !out_vld || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the query point
  always_ff @(posedge clk) begin
    if (acc_query) begin
      px   <= COORD_WIDTH'($unsigned(req.coord_x));
      py   <= COORD_WIDTH'($unsigned(req.coord_y));
      last <= req.last_point;
    end
  end

  // Advance the read counter; the final read wraps to vertex 0
  always_ff @(posedge clk) begin
    if (acc_query) begin
      rd_cnt <= '0;
    end else if (rd_issue) begin
      rd_cnt <= rd_cnt + VCNT_W'(1);
    end
  end

  assign rd_addr = (rd_cnt == n_eff) ? '0 : rd_cnt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag <= '0;
    end else begin
      rd_tag.vld   <= rd_issue;
      rd_tag.first <= (rd_cnt == '0);
    end
  end

  pip_vertex_mem u_mem (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (ADDR_W'(req.vertex_index)),
    .wr_data (wr_vtx),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pip_edge_unit u_edge (
    .clk    (clk),
    .rst    (rst),
    .clear  (acc_query),
    .tag    (rd_tag),
    .vtx    (rd_data),
    .px     (px),
    .py     (py),
    .parity (parity),
    .busy   (edge_busy)
  );

  // Group statistics including this point
  always_comb begin
    total_upd = (parity && (total != COUNT_MAX)) ? total + COUNT_W'(1) : total;
    seen_upd  = seen || parity;
    first_upd = (!seen && parity) ? pos : first_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      total     <= '0;
      first_pos <= '0;
      seen      <= 1'b0;
    end else if (finish) begin
      if (last) begin
        pos       <= '0;
        total     <= '0;
        first_pos <= '0;
        seen      <= 1'b0;
      end else begin
        pos       <= (pos != COUNT_MAX) ? pos + COUNT_W'(1) : pos;
        total     <= total_upd;
        first_pos <= first_upd;
        seen      <= seen_upd;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (finish) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      o_inside <= parity;
      o_num    <= pos;
      o_count  <= total_upd;
      o_any    <= seen_upd;
      o_first  <= seen_upd ? first_upd : '0;
      o_end    <= last;
    end
  end

  assign res.valid              = out_vld;
  assign res.inside_res         = o_inside;
  assign res.point_number       = o_num;
  assign res.inside_count       = o_count;
  assign res.any_inside         = o_any;
  assign res.first_inside_index = o_first;
  assign res.group_end          = o_end;

  // Vertex reads happen only during a walk
  a_read_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_tag.vld |-> (state == ST_WALK || state == ST_DRAIN))
    else $error("vertex read outside a walk");

  // The edge pipeline is empty before a result is formed
  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (!rd_tag.vld && !edge_busy))
    else $error("result formed with edges in flight");

  // Without an inside point the group figures are zero
  a_none_inside: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !o_any) |-> (o_first == '0 && o_count == '0))
    else $error("inside figures without an inside point");

  // A group end clears the group counters
  a_group_clear: assert property (@(posedge clk) disable iff (rst)
    (finish && last) |=> (pos == '0 && total == '0 && !seen))
    else $error("group counters not cleared at group end");

endmodule

`default_nettype wire
